// ----- rtl/reflected_crc32_byte_engine_assert.svh -----
`ifndef REFLECTED_CRC32_BYTE_ENGINE_ASSERT_SVH
`define REFLECTED_CRC32_BYTE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define RCRC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define RCRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/rcrc_pkg.sv -----
package rcrc_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB9_9320;
    localparam logic [CRC_W-1:0] SEED_RESET = 32'd1314520;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] seed;
    } rcrc_cfg_t;

    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  acc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        logic             lsb;
        c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            lsb = c[0];
            c   = c >> 1;
            if (lsb)
            begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/rcrc_cfg.sv -----
module rcrc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcrc_pkg::CRC_W-1:0]      cfg_data,
    output rcrc_pkg::rcrc_cfg_t             cfg
);
    import rcrc_pkg::*;

    logic [CRC_W-1:0] poly_reg;
    logic [CRC_W-1:0] seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
            seed_reg <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLY: poly_reg <= cfg_data;
                CFG_SEED: seed_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign cfg.poly = poly_reg;
    assign cfg.seed = seed_reg;

endmodule

// ----- rtl/rcrc_fold.sv -----
module rcrc_fold (
    input  logic [rcrc_pkg::CRC_W-1:0]  crc_in,
    input  logic [rcrc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        first_of_message,
    input  rcrc_pkg::rcrc_cfg_t         cfg,
    output logic [rcrc_pkg::CRC_W-1:0]  crc_out
);
    import rcrc_pkg::*;

    logic [CRC_W-1:0] start_crc;

    // A new message restarts from the inverted seed.
    assign start_crc = first_of_message ? ~cfg.seed : crc_in;
    assign crc_out   = fold_byte(start_crc, data_byte, cfg.poly);

endmodule

// ----- rtl/reflected_crc32_byte_engine.sv -----
// The last byte of a message is held in the input register, then its CRC is registered in the output register.
// Throughput: one byte per cycle; input stalls only while a finished CRC is not taken
// and the byte waiting in the input register is the last byte of another message.
// Reset (rst_n, asynchronous, active low) empties both stages, clears the running CRC
// and loads the polynomial and seed registers with their default values.
module reflected_crc32_byte_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic                            s_axis_tuser,   // [0] first_of_message
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // [31:0] crc_value
    input  logic                            cfg_we,
    input  logic [rcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcrc_pkg::CRC_W-1:0]      cfg_data
);
    import rcrc_pkg::*;

    rcrc_cfg_t        cfg;
    logic             in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic             out_valid_reg;
    logic [CRC_W-1:0] out_data_reg;
    logic             out_free;
    logic             advance;
    logic             s_accept;

    rcrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcrc_fold u_fold (
        .crc_in           (crc_reg),
        .data_byte        (in_byte_reg),
        .first_of_message (in_first_reg),
        .cfg              (cfg),
        .crc_out          (crc_next)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (advance)
        begin
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= ~crc_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- rtl/rcrc_checker.sv -----
module rcrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

`include "reflected_crc32_byte_engine_assert.svh"

    // The input side only stalls behind a finished CRC that is not being taken.
    `RCRC_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // A new result comes from an accepted last byte, by way of the input register and then the output register.
    `RCRC_ASSERT_IMPL(a_result_origin, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))

    `RCRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind reflected_crc32_byte_engine rcrc_checker u_rcrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
